// ===== hdl/stws_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Weighted sampler package
// Shared widths, default parameters, operation codes and controller states.
// ----------------------------------------------------------------------------
package stws_pkg;

   localparam int LEAVES_DEF      = 1024;
   localparam int WEIGHT_BITS_DEF = 16;
   localparam int RAND_BITS_DEF   = 16;

   localparam int INDEX_W  = 10;
   localparam int WEIGHT_W = 16;
   localparam int FRAC_W   = 16;
   localparam int CHUNK_W  = 16;

   localparam logic OP_SET  = 1'b0;
   localparam logic OP_DRAW = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ROOT_CHK,
      ST_SCALE,
      ST_DESC_RD,
      ST_DESC_CMP,
      ST_FIX_RD,
      ST_FIX_WR,
      ST_DONE
   } stws_state_type;

endpackage
`default_nettype wire

// ===== hdl/sum_tree_weighted_sampler_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Sum tree weighted sampler
// Leaf weight writes and weighted draws without replacement over a sum tree.
// ----------------------------------------------------------------------------
// D = tree depth (10 by default); set and draw walk the D levels of the tree.
// A draw scales the root sum by 16-bit slices of a node sum; an empty draw
// ends at the root check. One transaction at a time; the node memory port
// (one access a tree level, plus a write) sets the pace.
// Reset: all 2*LEAVES-1 nodes of the memory are cleared; no request taken.
// ----------------------------------------------------------------------------
module sum_tree_weighted_sampler_unit
   import stws_pkg::*;
#(
   parameter int LEAVES      = LEAVES_DEF,
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
   parameter int RAND_BITS   = RAND_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,  // leaf_index, weight, random_fraction
   input  wire logic [0:0]  req_tuser,  // operation
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata,  // drawn_index
   output logic      [0:0]  rsp_tuser   // empty_res
);

   localparam int NODE_W     = WEIGHT_BITS + $clog2(LEAVES);
   localparam int NODE_COUNT = 2 * LEAVES - 1;
   localparam int AW         = $clog2(NODE_COUNT);
   localparam logic [63:0] WMAX = (64'd1 << WEIGHT_BITS) - 64'd1;

   logic [INDEX_W-1:0]   req_index;
   logic [WEIGHT_W-1:0]  req_weight;
   logic [FRAC_W-1:0]    req_frac;
   logic                 leaf_ok;
   logic [AW-1:0]        leaf_node;
   logic [63:0]          weight_ext;
   logic [NODE_W-1:0]    weight_sat;
   logic [RAND_BITS-1:0] frac;

   logic                 scale_start;
   logic [NODE_W-1:0]    scale_total;
   logic [RAND_BITS-1:0] scale_frac;
   logic                 scale_busy;
   logic [NODE_W-1:0]    scale_target;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [NODE_W-1:0]    wr_data;
   logic [AW-1:0]        rd_addr;
   logic [NODE_W-1:0]    rd_data;

   logic [INDEX_W-1:0]   rsp_index;
   logic                 rsp_empty;

   assign req_index  = req_tdata[9:0];
   assign req_weight = req_tdata[25:10];
   assign req_frac   = req_tdata[41:26];

   assign leaf_ok    = {22'b0, req_index} < 32'(LEAVES);
   assign leaf_node  = AW'(32'(LEAVES - 1) + {22'b0, req_index});
   assign weight_ext = {48'b0, req_weight};
   assign weight_sat = NODE_W'((weight_ext > WMAX) ? WMAX : weight_ext);
   assign frac       = RAND_BITS'({16'b0, req_frac});

   assign rsp_tdata  = {6'b0, rsp_index};
   assign rsp_tuser  = rsp_empty;

   stws_ram #(
      .WIDTH (NODE_W),
      .DEPTH (NODE_COUNT)
   ) u_nodes (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   stws_scale #(
      .NODE_W    (NODE_W),
      .RAND_BITS (RAND_BITS)
   ) u_scale (
      .clock  (clock),
      .reset  (reset),
      .start  (scale_start),
      .total  (scale_total),
      .frac   (scale_frac),
      .busy   (scale_busy),
      .target (scale_target)
   );

   stws_ctrl #(
      .LEAVES    (LEAVES),
      .NODE_W    (NODE_W),
      .RAND_BITS (RAND_BITS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .op           (req_tuser[0]),
      .leaf_ok      (leaf_ok),
      .leaf_node    (leaf_node),
      .weight_sat   (weight_sat),
      .frac         (frac),
      .scale_start  (scale_start),
      .scale_total  (scale_total),
      .scale_frac   (scale_frac),
      .scale_busy   (scale_busy),
      .scale_target (scale_target),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_index    (rsp_index),
      .rsp_empty    (rsp_empty)
   );

endmodule
`default_nettype wire

// ===== hdl/stws_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module stws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== hdl/stws_scale.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Target scaler
// floor(total * frac / 2^RAND_BITS), one 16-bit slice of the total a cycle.
// ----------------------------------------------------------------------------
module stws_scale
   import stws_pkg::*;
#(
   parameter int NODE_W    = 26,
   parameter int RAND_BITS = RAND_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [NODE_W-1:0]    total,
   input  wire logic [RAND_BITS-1:0] frac,
   output logic                      busy,
   output logic      [NODE_W-1:0]    target
);

   localparam int CHUNKS = (NODE_W + CHUNK_W - 1) / CHUNK_W;
   localparam int TW     = CHUNKS * CHUNK_W;
   localparam int PW     = TW + RAND_BITS;
   localparam int MW     = CHUNK_W + RAND_BITS;
   localparam int CW     = $clog2(CHUNKS + 1);

   logic [TW-1:0] tot_ff;
   logic [PW-1:0] acc_ff;
   logic [PW-1:0] acc_in;
   logic [CW-1:0] cnt_ff;
   logic [MW-1:0] prod;

   assign prod   = MW'(tot_ff[TW-1 -: CHUNK_W]) * MW'(frac);
   assign acc_in = (acc_ff << CHUNK_W) + PW'(prod);
   assign busy   = (cnt_ff != '0);
   assign target = acc_ff[RAND_BITS +: NODE_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= CW'(CHUNKS);
      end else if (busy) begin
         cnt_ff <= cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         tot_ff <= TW'(total);
         acc_ff <= '0;
      end else if (busy) begin
         tot_ff <= tot_ff << CHUNK_W;
         acc_ff <= acc_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/stws_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Sum tree controller
// Clears the tree, walks it for draws, rewrites leaf paths, holds the result.
// ----------------------------------------------------------------------------
module stws_ctrl
   import stws_pkg::*;
#(
   parameter int LEAVES    = LEAVES_DEF,
   parameter int NODE_W    = 26,
   parameter int RAND_BITS = RAND_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic                             op,
   input  wire logic                             leaf_ok,
   input  wire logic [$clog2(2*LEAVES-1)-1:0]    leaf_node,
   input  wire logic [NODE_W-1:0]                weight_sat,
   input  wire logic [RAND_BITS-1:0]             frac,
   output logic                                  scale_start,
   output logic      [NODE_W-1:0]                scale_total,
   output logic      [RAND_BITS-1:0]             scale_frac,
   input  wire logic                             scale_busy,
   input  wire logic [NODE_W-1:0]                scale_target,
   output logic                                  wr_en,
   output logic      [$clog2(2*LEAVES-1)-1:0]    wr_addr,
   output logic      [NODE_W-1:0]                wr_data,
   output logic      [$clog2(2*LEAVES-1)-1:0]    rd_addr,
   input  wire logic [NODE_W-1:0]                rd_data,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic      [INDEX_W-1:0]               rsp_index,
   output logic                                  rsp_empty
);

   localparam int NODE_COUNT = 2 * LEAVES - 1;
   localparam int INNER      = LEAVES - 1;
   localparam int AW         = $clog2(NODE_COUNT);

   stws_state_type     state_ff, state_in;
   logic [AW-1:0]      node_ff, node_in;
   logic [NODE_W-1:0]  cur_ff, cur_in;
   logic [NODE_W-1:0]  x_ff, x_in;
   logic [RAND_BITS-1:0] frac_ff, frac_in;
   logic [INDEX_W-1:0] pend_idx_ff, pend_idx_in;
   logic               pend_empty_ff, pend_empty_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0] rsp_index_ff;
   logic               rsp_empty_ff;
   logic               rsp_load;

   logic [AW-1:0]      left;
   logic [AW-1:0]      node_dec;
   logic [AW-1:0]      parent;
   logic [AW-1:0]      sibling;
   logic [NODE_W-1:0]  path_sum;

   assign left     = AW'({node_ff, 1'b1});
   assign node_dec = node_ff - AW'(1);
   assign parent   = {1'b0, node_dec[AW-1:1]};
   assign sibling  = node_ff[0] ? (node_ff + AW'(1)) : node_dec;
   assign path_sum = cur_ff + rd_data;

   assign scale_total = rd_data;
   assign scale_frac  = frac_ff;
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_index   = rsp_index_ff;
   assign rsp_empty   = rsp_empty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         node_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         node_ff      <= node_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      x_ff          <= x_in;
      frac_ff       <= frac_in;
      pend_idx_ff   <= pend_idx_in;
      pend_empty_ff <= pend_empty_in;
      if (rsp_load) begin
         rsp_index_ff <= pend_idx_ff;
         rsp_empty_ff <= pend_empty_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      node_in       = node_ff;
      cur_in        = cur_ff;
      x_in          = x_ff;
      frac_in       = frac_ff;
      pend_idx_in   = pend_idx_ff;
      pend_empty_in = pend_empty_ff;
      req_tready    = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = node_ff;
      wr_data       = '0;
      rd_addr       = '0;
      scale_start   = 1'b0;
      rsp_load      = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            if (node_ff == AW'(NODE_COUNT - 1)) begin
               node_in  = '0;
               state_in = ST_IDLE;
            end else begin
               node_in = node_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               frac_in       = frac;
               pend_idx_in   = '0;
               pend_empty_in = 1'b0;
               if (op == OP_DRAW) begin
                  state_in = ST_ROOT_CHK;
               end else if (leaf_ok) begin
                  wr_en    = 1'b1;
                  wr_addr  = leaf_node;
                  wr_data  = weight_sat;
                  node_in  = leaf_node;
                  cur_in   = weight_sat;
                  state_in = ST_FIX_RD;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_ROOT_CHK: begin
            if (rd_data == '0) begin
               pend_empty_in = 1'b1;
               state_in      = ST_DONE;
            end else begin
               scale_start = 1'b1;
               state_in    = ST_SCALE;
            end
         end
         ST_SCALE: begin
            if (!scale_busy) begin
               x_in     = scale_target;
               node_in  = '0;
               state_in = ST_DESC_RD;
            end
         end
         ST_DESC_RD: begin
            if (node_ff >= AW'(INNER)) begin
               wr_en       = 1'b1;
               cur_in      = '0;
               pend_idx_in = INDEX_W'(node_ff - AW'(INNER));
               state_in    = ST_FIX_RD;
            end else begin
               rd_addr  = left;
               state_in = ST_DESC_CMP;
            end
         end
         ST_DESC_CMP: begin
            if (x_ff >= rd_data) begin
               x_in    = x_ff - rd_data;
               node_in = left + AW'(1);
            end else begin
               node_in = left;
            end
            state_in = ST_DESC_RD;
         end
         ST_FIX_RD: begin
            if (node_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               rd_addr  = sibling;
               state_in = ST_FIX_WR;
            end
         end
         ST_FIX_WR: begin
            wr_en    = 1'b1;
            wr_addr  = parent;
            wr_data  = path_sum;
            cur_in   = path_sum;
            node_in  = parent;
            state_in = ST_FIX_RD;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_tready);
   end

endmodule
`default_nettype wire

// ===== test/tb_sum_tree_weighted_sampler_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sum tree weighted sampler testbench
// Drives leaf weight writes and weighted draws into the sampler and checks
// every result against a sum tree kept in the scoreboard. The stimulus covers
// empty draws, extreme fractions and weights, and the rewriting of live leaves.
// It also fills the tree and drains it through and past empty, with random
// stalls on both streams and one long hold-off on the result side.
// ----------------------------------------------------------------------------
module tb_sum_tree_weighted_sampler_unit;
   import stws_pkg::*;

   localparam int TREE_LEAVES     = LEAVES_DEF;
   localparam int INNER_NODES     = TREE_LEAVES - 1;
   localparam int TREE_NODES      = 2 * TREE_LEAVES - 1;
   localparam int SUM_W           = WEIGHT_W + $clog2(TREE_LEAVES);
   localparam int ITEM_TOTAL      = 1500;
   localparam int TAIL_START      = 1300;
   localparam int HOLD_OFF_AT     = 300;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 200;
   localparam int CYCLE_LIMIT     = 1000000;

   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic               empty;
   } pick_type;

   class pick_scoreboard;
      logic [SUM_W-1:0] node_sum [TREE_NODES];
      pick_type         expected_picks [$];
      int               errors;
      int               checked;

      function new();
         foreach (node_sum[i]) node_sum[i] = '0;
         errors  = 0;
         checked = 0;
      endfunction

      task report(string what);
         $display("[%0t] mismatch: %s", $time, what);
         errors++;
      endtask

      function void refresh_path(int node);
         while (node > 0) begin
            node = (node - 1) / 2;
            node_sum[node] = node_sum[2 * node + 1] + node_sum[2 * node + 2];
         end
      endfunction

      function int live_leaves();
         int n;
         n = 0;
         for (int j = 0; j < TREE_LEAVES; j++) begin
            if (node_sum[INNER_NODES + j] != 0) n++;
         end
         return n;
      endfunction

      function void note_request(logic op, logic [INDEX_W-1:0] idx,
                                 logic [WEIGHT_W-1:0] w, logic [FRAC_W-1:0] frac);
         pick_type                pick;
         logic [SUM_W+FRAC_W-1:0] target;
         int                      node;
         pick = '0;
         if (op == OP_SET) begin
            node = INNER_NODES + int'(idx);
            node_sum[node] = SUM_W'(w);
            refresh_path(node);
         end else if (node_sum[0] == 0) begin
            pick.empty = 1'b1;
         end else begin
            target = {{FRAC_W{1'b0}}, node_sum[0]} * {{SUM_W{1'b0}}, frac};
            target = target >> FRAC_W;
            node = 0;
            while (node < INNER_NODES) begin
               if (target >= node_sum[2 * node + 1]) begin
                  target = target - node_sum[2 * node + 1];
                  node   = 2 * node + 2;
               end else begin
                  node = 2 * node + 1;
               end
            end
            node_sum[node] = '0;
            refresh_path(node);
            pick.index = INDEX_W'(node - INNER_NODES);
         end
         expected_picks = {expected_picks, pick};
      endfunction

      task check_response(logic [15:0] data, logic empty);
         pick_type pick;
         checked++;
         if (expected_picks.size() == 0) begin
            report($sformatf("unexpected result, index %0d empty %0b", data, empty));
            return;
         end
         pick = expected_picks.pop_front();
         if (data !== {{(16 - INDEX_W){1'b0}}, pick.index})
            report($sformatf("drawn index %0d, predicted %0d", data, pick.index));
         if (empty !== pick.empty)
            report($sformatf("empty flag %0b, predicted %0b", empty, pick.empty));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;   // leaf_index, weight, random_fraction
   logic [0:0]  req_tuser;   // operation
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // drawn_index
   logic [0:0]  rsp_tuser;   // empty_res

   pick_scoreboard sb;
   int             sent = 0;
   int             cycles = 0;
   bit             idle_on = 0;
   bit             quiet_tail = 0;
   bit             held_off = 0;

   sum_tree_weighted_sampler_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         sb.note_request(req_tuser[0], req_tdata[9:0], req_tdata[25:10], req_tdata[41:26]);
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata, rsp_tuser[0]);
   end

   // result side: random stalls, one long hold-off to back up the input
   initial begin
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if (!held_off && !quiet_tail && sb.checked >= HOLD_OFF_AT) begin
            held_off = 1;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else if (idle_on && !quiet_tail && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(negedge clock);
      end
   end

   task automatic send_item(logic op, logic [INDEX_W-1:0] idx,
                            logic [WEIGHT_W-1:0] w, logic [FRAC_W-1:0] frac);
      if (idle_on && !quiet_tail && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {6'b0, frac, w, idx};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      sent++;
      quiet_tail = (sent >= TAIL_START);
   endtask

   function automatic logic [WEIGHT_W-1:0] pick_weight();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3:    return WEIGHT_W'($urandom_range(1, 15));
         default: return WEIGHT_W'($urandom);
      endcase
   endfunction

   task automatic directed_items();
      send_item(OP_DRAW, '1, '1, '1);
      send_item(OP_SET, 0, '1, 0);
      send_item(OP_SET, INDEX_W'(TREE_LEAVES - 1), 1, '1);
      send_item(OP_SET, INDEX_W'(TREE_LEAVES / 2), 16'h8000, 0);
      send_item(OP_DRAW, 0, 0, 16'h0000);
      send_item(OP_DRAW, 0, 0, 16'hFFFF);
      send_item(OP_DRAW, '1, '1, 16'h8000);
      send_item(OP_DRAW, 0, 0, 0);
      send_item(OP_SET, 5, 100, 0);
      send_item(OP_SET, 5, 0, 0);
      send_item(OP_DRAW, 0, 0, 16'h1234);
      send_item(OP_SET, 7, 10, 0);
      send_item(OP_SET, 7, 20, '1);
      send_item(OP_SET, 300, 20, 0);
      send_item(OP_DRAW, 0, 0, 16'h7FFF);
      send_item(OP_DRAW, 0, 0, 16'h8000);
      send_item(OP_DRAW, 0, 0, 16'hFFFF);
      send_item(OP_SET, '1, '1, '1);
      send_item(OP_DRAW, '1, 0, 16'hFFFF);
      send_item(OP_DRAW, 0, '1, 0);
   endtask

   task automatic random_items();
      int n;
      int m;
      int base;
      bit clustered;
      logic [INDEX_W-1:0] leaf;
      while (sent < ITEM_TOTAL) begin
         idle_on = ($urandom_range(0, 3) != 0) && !quiet_tail;
         if ($urandom_range(0, 2) != 0) begin
            // fill some leaves, then draw a share or drain past empty
            n = $urandom_range(1, 40);
            base = $urandom_range(0, TREE_LEAVES - 1);
            clustered = ($urandom_range(0, 1) != 0);
            for (int k = 0; k < n; k++) begin
               leaf = clustered ? INDEX_W'(base + $urandom_range(0, 15)) : INDEX_W'($urandom);
               send_item(OP_SET, leaf, pick_weight(), FRAC_W'($urandom));
            end
            m = sb.live_leaves();
            if ($urandom_range(0, 2) != 0) m = m + 1 + $urandom_range(0, 1);
            else m = $urandom_range(1, m + 1);
            for (int k = 0; k < m; k++)
               send_item(OP_DRAW, INDEX_W'($urandom), WEIGHT_W'($urandom), FRAC_W'($urandom));
         end else begin
            for (int k = 0; k < 30; k++) begin
               if ($urandom_range(0, 1) == 0)
                  send_item(OP_SET, INDEX_W'($urandom), pick_weight(), FRAC_W'($urandom));
               else
                  send_item(OP_DRAW, INDEX_W'($urandom), WEIGHT_W'($urandom),
                            FRAC_W'($urandom));
            end
         end
      end
   endtask

   initial begin
      sb = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      directed_items();
      random_items();
      req_tvalid <= 1'b0;
      while (sb.expected_picks.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (sb.errors == 0 && sb.expected_picks.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
